/* rtl/ffba_pkg.sv */
// Shared constants and operation codes of the first-fit block allocator.
package ffba_pkg;

	localparam int HEAP_BYTES   = 512;	// heap size, bytes
	localparam int HEADER_BYTES = 8;	// block header size, bytes

	localparam int REQ_W = 10;	// request size field
	localparam int OFF_W = 9;	// payload offset fields

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

endpackage

/* rtl/ffba_req_if.sv */
// Request channel of the allocator: operation, size and offset with valid/ready.
interface ffba_req_if;
	import ffba_pkg::*;

	logic             valid;
	logic             ready;
	logic             operation;
	logic [REQ_W-1:0] request_bytes;
	logic [OFF_W-1:0] payload_offset;

	modport source (output valid, output operation, output request_bytes,
		output payload_offset, input ready);
	modport sink (input valid, input operation, input request_bytes,
		input payload_offset, output ready);
endinterface

/* rtl/ffba_rsp_if.sv */
// Response channel of the allocator: grant flag and payload offset with valid/ready.
interface ffba_rsp_if;
	import ffba_pkg::*;

	logic             valid;
	logic             ready;
	logic             granted;
	logic [OFF_W-1:0] block_offset;

	modport source (output valid, output granted, output block_offset, input ready);
	modport sink (input valid, input granted, input block_offset, output ready);
endinterface

/* rtl/first_fit_block_allocator.sv */
// First-fit block allocator: sequencer walking boundary-tagged block headers.
// Usage: requests arrive on req (operation, request_bytes, payload_offset) and one
// response per request leaves on rsp (granted, block_offset); a beat moves when
// valid and ready are both high. One request is worked on at a time.
// Allocate walks the block chain from offset 0, reading each block header and
// then checking it, and on a split writes the new header and fixes the back
// size of the block after it. Free walks the chain to the named block the same
// way, then merges it with the following and preceding blocks when they are free.
// The header memory, used as a single port (one read or one write per cycle),
// sets the pace. A finished response is loaded from S_DONE into an output
// register; req is ready again as soon as that register is loaded, so the next
// request is taken while a response still waits. If rsp stalls, the following
// request finishes its walk and then waits until the output register is free.
// After reset the heap is one free block at offset 0; no clearing pass is
// needed, the block is ready as soon as reset is released.
module first_fit_block_allocator (
	input  logic       clk,
	input  logic       arst_n,
	ffba_req_if.sink   req,
	ffba_rsp_if.source rsp
);
	import ffba_pkg::*;

	localparam int AW = $clog2(HEAP_BYTES);
	localparam int SW = AW + 1;
	localparam int CW = ((SW > REQ_W) ? SW : REQ_W) + 1;
	localparam logic [CW-1:0] HEAP_C = CW'(HEAP_BYTES);
	localparam logic [CW-1:0] HDR_C  = CW'(HEADER_BYTES);

	typedef enum logic [3:0] {
		S_IDLE, S_A_RD, S_A_CHK, S_A_SPLIT, S_A_AFTER,
		S_F_RD, S_F_CHK, S_F_NXT, S_F_NXT_CHK, S_F_BEYOND,
		S_F_PREV, S_F_PREV_CHK, S_F_PBEYOND, S_FIX_RD, S_FIX_WR, S_DONE
	} state_t;

	state_t           state_q, ret_q;
	logic [REQ_W-1:0] n_q;
	logic [SW-1:0]    loc_q;
	logic [AW-1:0]    h_q, cur_prior_q, cur_size_q, fix_addr_q, fix_val_q;
	logic             res_ok_q, out_valid_q, out_ok_q;
	logic [OFF_W-1:0] res_off_q, out_off_q;
	logic             rsp_load;

	logic          rd_en, wr_en, rd_free, wr_free;
	logic [AW-1:0] rd_addr, wr_addr, rd_prior, rd_size, wr_prior, wr_size;

	logic [CW-1:0] alu_a, alu_b, alu_sum;
	logic [CW-1:0] loc_c, h_c, pay_c, need_c, rest_c, prev_lim_c, pl_c;
	logic [CW-1:0] in_off_c, in_h_c;
	logic          sum_in_heap, fit_free, exact, big, prev_ok;

	ffba_hdr_store #(
		.HEAP_BYTES  (HEAP_BYTES),
		.HEADER_BYTES(HEADER_BYTES)
	) u_hdr (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_free (rd_free),
		.rd_prior(rd_prior),
		.rd_size (rd_size),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_free (wr_free),
		.wr_prior(wr_prior),
		.wr_size (wr_size)
	);

	// shared address/size adder: a + b + header
	assign alu_sum     = alu_a + alu_b + HDR_C;
	assign sum_in_heap = alu_sum < HEAP_C;

	assign loc_c      = CW'(loc_q);
	assign h_c        = CW'(h_q);
	assign pay_c      = loc_c + HDR_C;
	assign need_c     = CW'(n_q) + HDR_C;
	assign rest_c     = CW'(cur_size_q) - need_c;
	assign prev_lim_c = CW'(cur_prior_q) + HDR_C;
	assign pl_c       = h_c - prev_lim_c;
	assign in_off_c   = CW'(req.payload_offset);
	assign in_h_c     = in_off_c - HDR_C;

	assign fit_free = rd_free && (pay_c < HEAP_C);
	assign exact    = CW'(rd_size) == CW'(n_q);
	assign big      = CW'(rd_size) >= need_c;
	assign prev_ok  = (h_q != '0) && (prev_lim_c <= h_c);

	// response register takes a beat when empty or being drained
	assign rsp_load = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = loc_q[AW-1:0];
		wr_en    = 1'b0;
		wr_addr  = loc_q[AW-1:0];
		wr_free  = 1'b0;
		wr_prior = rd_prior;
		wr_size  = rd_size;
		alu_a    = loc_c;
		alu_b    = CW'(rd_size);
		unique case (state_q)
			S_A_RD, S_F_RD: begin
				rd_en = loc_c < HEAP_C;
			end
			S_A_CHK: begin
				wr_en   = fit_free && (exact || big);
				wr_size = exact ? rd_size : n_q[AW-1:0];
			end
			S_A_SPLIT: begin
				alu_b    = CW'(n_q);
				wr_en    = sum_in_heap;
				wr_addr  = alu_sum[AW-1:0];
				wr_free  = 1'b1;
				wr_prior = n_q[AW-1:0];
				wr_size  = rest_c[AW-1:0];
			end
			S_A_AFTER: begin
				alu_b = CW'(cur_size_q);
			end
			S_F_CHK: begin
				wr_en   = (loc_c == h_c) && !rd_free;
				wr_addr = h_q;
				wr_free = 1'b1;
			end
			S_F_NXT: begin
				alu_a   = h_c;
				alu_b   = CW'(cur_size_q);
				rd_en   = sum_in_heap;
				rd_addr = alu_sum[AW-1:0];
			end
			S_F_NXT_CHK: begin
				alu_a    = CW'(cur_size_q);
				wr_en    = rd_free;
				wr_addr  = h_q;
				wr_free  = 1'b1;
				wr_prior = cur_prior_q;
				wr_size  = alu_sum[AW-1:0];
			end
			S_F_BEYOND, S_F_PBEYOND: begin
				alu_a = h_c;
				alu_b = CW'(cur_size_q);
			end
			S_F_PREV: begin
				rd_en   = prev_ok;
				rd_addr = pl_c[AW-1:0];
			end
			S_F_PREV_CHK: begin
				alu_a   = CW'(rd_size);
				alu_b   = CW'(cur_size_q);
				wr_en   = rd_free;
				wr_addr = fix_addr_q;
				wr_free = 1'b1;
				wr_size = alu_sum[AW-1:0];
			end
			S_FIX_RD: begin
				rd_en   = 1'b1;
				rd_addr = fix_addr_q;
			end
			S_FIX_WR: begin
				wr_en    = 1'b1;
				wr_addr  = fix_addr_q;
				wr_free  = rd_free;
				wr_prior = fix_val_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_DONE;
			n_q         <= '0;
			loc_q       <= '0;
			h_q         <= '0;
			cur_prior_q <= '0;
			cur_size_q  <= '0;
			fix_addr_q  <= '0;
			fix_val_q   <= '0;
			res_ok_q    <= 1'b0;
			res_off_q   <= '0;
			out_valid_q <= 1'b0;
			out_ok_q    <= 1'b0;
			out_off_q   <= '0;
		end else begin
			if (rsp_load)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						n_q       <= req.request_bytes;
						loc_q     <= '0;
						res_ok_q  <= 1'b0;
						res_off_q <= '0;
						if (req.operation == OP_ALLOC) begin
							state_q <= S_A_RD;
						end else if (in_off_c < HDR_C || in_h_c >= HEAP_C) begin
							state_q <= S_DONE;
						end else begin
							h_q     <= in_h_c[AW-1:0];
							state_q <= S_F_RD;
						end
					end
				end
				S_A_RD: begin
					state_q <= (loc_c < HEAP_C) ? S_A_CHK : S_DONE;
				end
				S_A_CHK: begin
					if (fit_free && exact) begin
						res_ok_q  <= 1'b1;
						res_off_q <= pay_c[OFF_W-1:0];
						state_q   <= S_DONE;
					end else if (fit_free && big) begin
						res_ok_q   <= 1'b1;
						res_off_q  <= pay_c[OFF_W-1:0];
						cur_size_q <= rd_size;
						state_q    <= S_A_SPLIT;
					end else begin
						loc_q   <= alu_sum[SW-1:0];
						state_q <= S_A_RD;
					end
				end
				S_A_SPLIT: begin
					fix_val_q <= rest_c[AW-1:0];
					state_q   <= S_A_AFTER;
				end
				S_A_AFTER: begin
					// back size of the block after the split one
					fix_addr_q <= alu_sum[AW-1:0];
					ret_q      <= S_DONE;
					state_q    <= sum_in_heap ? S_FIX_RD : S_DONE;
				end
				S_F_RD: begin
					state_q <= (loc_c < HEAP_C) ? S_F_CHK : S_DONE;
				end
				S_F_CHK: begin
					if (loc_c == h_c) begin
						cur_prior_q <= rd_prior;
						cur_size_q  <= rd_size;
						state_q     <= rd_free ? S_DONE : S_F_NXT;
					end else if (loc_c > h_c) begin
						state_q <= S_DONE;
					end else begin
						loc_q   <= alu_sum[SW-1:0];
						state_q <= S_F_RD;
					end
				end
				S_F_NXT: begin
					state_q <= sum_in_heap ? S_F_NXT_CHK : S_F_PREV;
				end
				S_F_NXT_CHK: begin
					if (rd_free) begin
						cur_size_q <= alu_sum[AW-1:0];
						fix_val_q  <= alu_sum[AW-1:0];
						state_q    <= S_F_BEYOND;
					end else begin
						state_q <= S_F_PREV;
					end
				end
				S_F_BEYOND: begin
					fix_addr_q <= alu_sum[AW-1:0];
					ret_q      <= S_F_PREV;
					state_q    <= sum_in_heap ? S_FIX_RD : S_F_PREV;
				end
				S_F_PREV: begin
					if (prev_ok) begin
						fix_addr_q <= pl_c[AW-1:0];
						state_q    <= S_F_PREV_CHK;
					end else begin
						res_ok_q <= 1'b1;
						state_q  <= S_DONE;
					end
				end
				S_F_PREV_CHK: begin
					res_ok_q <= 1'b1;
					if (rd_free) begin
						fix_val_q <= alu_sum[AW-1:0];
						state_q   <= S_F_PBEYOND;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_F_PBEYOND: begin
					fix_addr_q <= alu_sum[AW-1:0];
					ret_q      <= S_DONE;
					state_q    <= sum_in_heap ? S_FIX_RD : S_DONE;
				end
				S_FIX_RD: begin
					state_q <= S_FIX_WR;
				end
				S_FIX_WR: begin
					state_q <= ret_q;
				end
				S_DONE: begin
					if (rsp_load) begin
						out_ok_q  <= res_ok_q;
						out_off_q <= res_off_q;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready        = state_q == S_IDLE;
	assign rsp.valid        = out_valid_q;
	assign rsp.granted      = out_ok_q;
	assign rsp.block_offset = out_off_q;

	a_fail_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.granted |-> rsp.block_offset == '0)
		else $error("refused request carries a non-zero offset");

	a_alloc_walk_advances: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q) == S_A_CHK && state_q == S_A_RD |-> loc_q > $past(loc_q))
		else $error("allocate walk did not move forward");

	a_free_walk_advances: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q) == S_F_CHK && state_q == S_F_RD |-> loc_q > $past(loc_q))
		else $error("free walk did not move forward");

	a_single_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("header read and write in the same cycle");

	a_write_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> CW'(wr_addr) < HEAP_C)
		else $error("header write outside the heap");

endmodule

/* rtl/ffba_hdr_store.sv */
// Block header memory, one header per byte offset, with the reset header at offset 0.
module ffba_hdr_store #(
	parameter int HEAP_BYTES   = 512,
	parameter int HEADER_BYTES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [$clog2(HEAP_BYTES)-1:0] rd_addr,
	output logic                          rd_free,
	output logic [$clog2(HEAP_BYTES)-1:0] rd_prior,
	output logic [$clog2(HEAP_BYTES)-1:0] rd_size,
	input  logic                          wr_en,
	input  logic [$clog2(HEAP_BYTES)-1:0] wr_addr,
	input  logic                          wr_free,
	input  logic [$clog2(HEAP_BYTES)-1:0] wr_prior,
	input  logic [$clog2(HEAP_BYTES)-1:0] wr_size
);
	localparam int AW = $clog2(HEAP_BYTES);
	localparam int HW = 1 + 2 * AW;
	localparam logic [AW-1:0] FIRST_SIZE = AW'(HEAP_BYTES - HEADER_BYTES);

	logic [HW-1:0] mem [HEAP_BYTES];
	logic [HW-1:0] rd_data_s1;
	logic          rd_blank_s1;
	logic          first_written_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= {wr_free, wr_prior, wr_size};
		if (rd_en)
			rd_data_s1 <= mem[rd_addr];
	end

	// header 0 holds the whole-heap free block until it is first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_written_q <= 1'b0;
			rd_blank_s1     <= 1'b0;
		end else begin
			if (wr_en && wr_addr == '0)
				first_written_q <= 1'b1;
			if (rd_en)
				rd_blank_s1 <= (rd_addr == '0) && !first_written_q;
		end
	end

	assign rd_free  = rd_blank_s1 ? 1'b1 : rd_data_s1[HW-1];
	assign rd_prior = rd_blank_s1 ? '0 : rd_data_s1[2*AW-1:AW];
	assign rd_size  = rd_blank_s1 ? FIRST_SIZE : rd_data_s1[AW-1:0];

endmodule
